// File: hw/rtl/gpf_pkg.sv
package gpf_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int STORE_DEPTH  = 64;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);
    localparam int IDX_W        = 3;
    localparam int CNT_W        = ADDR_W + 1;
    localparam int ROWCNT_W     = 4;
    localparam int DEF_COLS     = 8;
    localparam int DEF_MAX_ROWS = 8;

    localparam logic [ROWCNT_W-1:0] ROW_COUNT_RESET = 4'd8;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              cap_center;
        logic              cmp_en;
        logic              cmp_valid;
        logic              scan_start;
        logic              out_load;
        logic [IDX_W-1:0]  out_row;
        logic [IDX_W-1:0]  out_col;
        logic              frame_end;
    } gpf_cmd_t;

    typedef struct packed {
        logic out_stall;
    } gpf_stat_t;

endpackage

// File: hw/rtl/gpf_ctrl.sv
module gpf_ctrl #(
    parameter int COLS     = gpf_pkg::DEF_COLS,
    parameter int MAX_ROWS = gpf_pkg::DEF_MAX_ROWS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [gpf_pkg::ROWCNT_W-1:0]  cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  gpf_pkg::gpf_stat_t            stat,
    output gpf_pkg::gpf_cmd_t             cmd
);
    import gpf_pkg::*;

    typedef enum logic [4:0] {
        ST_LOAD   = 5'b00001,
        ST_CENTER = 5'b00010,
        ST_NB     = 5'b00100,
        ST_CMP    = 5'b01000,
        ST_EMIT   = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [ROWCNT_W-1:0] row_count_reg;
    logic [ROWCNT_W-1:0] rows_eff;
    logic [CNT_W-1:0]    total;
    logic [CNT_W-1:0]    loaded_reg, loaded_next, loaded_inc;
    logic [IDX_W-1:0]    row_reg, row_next;
    logic [IDX_W-1:0]    col_reg, col_next;
    logic [1:0]          nb_reg, nb_next;
    logic                prev_vld_reg, prev_vld_next;
    logic [ADDR_W-1:0]   center_addr;
    logic [ADDR_W-1:0]   nb_addr;
    logic [3:0]          nb_vld;
    logic                last_col, last_row;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_LOAD);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg <= ROW_COUNT_RESET;
        end else if (cfg_valid) begin
            row_count_reg <= cfg_data;
        end
    end

    // zero acts as one row, anything above the maximum as the maximum
    always_comb begin
        if (row_count_reg == '0) begin
            rows_eff = ROWCNT_W'(1);
        end else if (row_count_reg > ROWCNT_W'(MAX_ROWS)) begin
            rows_eff = ROWCNT_W'(MAX_ROWS);
        end else begin
            rows_eff = row_count_reg;
        end
    end

    assign total       = CNT_W'(CNT_W'(rows_eff) * CNT_W'(COLS));
    assign loaded_inc  = loaded_reg + CNT_W'(1);
    assign center_addr = ADDR_W'(ADDR_W'(row_reg) * ADDR_W'(COLS)) + ADDR_W'(col_reg);

    // neighbor order: up, left, right, down
    assign nb_vld[0] = (row_reg != '0);
    assign nb_vld[1] = (col_reg != '0);
    assign nb_vld[2] = ((4'(col_reg) + 4'd1) < 4'(COLS));
    assign nb_vld[3] = ((4'(row_reg) + 4'd1) < rows_eff);

    always_comb begin
        case (nb_reg)
            2'd0:    nb_addr = center_addr - ADDR_W'(COLS);
            2'd1:    nb_addr = center_addr - ADDR_W'(1);
            2'd2:    nb_addr = center_addr + ADDR_W'(1);
            default: nb_addr = center_addr + ADDR_W'(COLS);
        endcase
    end

    assign last_col = (col_reg == IDX_W'(COLS - 1));
    assign last_row = (4'(row_reg) == (rows_eff - 4'd1));

    function automatic logic [ADDR_W-1:0] nb_valid_addr(input logic vld,
                                                         input logic [ADDR_W-1:0] a,
                                                         input logic [ADDR_W-1:0] c);
        nb_valid_addr = vld ? a : c;
    endfunction

    always_comb begin
        state_next    = state_reg;
        loaded_next   = loaded_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        nb_next       = nb_reg;
        prev_vld_next = prev_vld_reg;
        cmd           = '0;
        cmd.wr_addr   = loaded_reg[ADDR_W-1:0];
        cmd.out_row   = row_reg;
        cmd.out_col   = col_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (s_valid) begin
                    cmd.wr_en = 1'b1;
                    if (loaded_inc >= total) begin
                        loaded_next    = '0;
                        row_next       = '0;
                        col_next       = '0;
                        cmd.scan_start = 1'b1;
                        state_next     = ST_CENTER;
                    end else begin
                        loaded_next = loaded_inc;
                    end
                end
            end
            ST_CENTER: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = center_addr;
                nb_next     = '0;
                state_next  = ST_NB;
            end
            ST_NB: begin
                // read data is registered and arrives in the cycle after its address
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = nb_valid_addr(nb_vld[nb_reg], nb_addr, center_addr);
                if (nb_reg == 2'd0) begin
                    cmd.cap_center = 1'b1;
                end else begin
                    cmd.cmp_en    = 1'b1;
                    cmd.cmp_valid = prev_vld_reg;
                end
                prev_vld_next = nb_vld[nb_reg];
                nb_next       = nb_reg + 2'd1;
                if (nb_reg == 2'd3) begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                cmd.cmp_en    = 1'b1;
                cmd.cmp_valid = prev_vld_reg;
                state_next    = ST_EMIT;
            end
            ST_EMIT: begin
                cmd.frame_end = last_col && last_row;
                if (!stat.out_stall) begin
                    cmd.out_load = 1'b1;
                    if (last_col && last_row) begin
                        state_next = ST_LOAD;
                    end else begin
                        if (last_col) begin
                            col_next = '0;
                            row_next = row_reg + IDX_W'(1);
                        end else begin
                            col_next = col_reg + IDX_W'(1);
                        end
                        state_next = ST_CENTER;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            loaded_reg   <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
            nb_reg       <= '0;
            prev_vld_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            loaded_reg   <= loaded_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            nb_reg       <= nb_next;
            prev_vld_reg <= prev_vld_next;
        end
    end

    a_last_emit_to_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_load && cmd.frame_end) |=> (state_reg == ST_LOAD))
        else $error("scan did not return to loading after the last cell");

    a_scan_in_grid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_LOAD) |-> (CNT_W'(center_addr) < total))
        else $error("scan position outside the grid");

    a_state_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("state register not one-hot");

endmodule

// File: hw/rtl/gpf_datapath.sv
module gpf_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic signed [gpf_pkg::SAMPLE_W-1:0] s_sample,
    input  gpf_pkg::gpf_cmd_t                   cmd,
    output gpf_pkg::gpf_stat_t                  stat,
    input  logic                                m_ready,
    output logic                                m_valid,
    output logic [gpf_pkg::IDX_W-1:0]           m_row_index,
    output logic [gpf_pkg::IDX_W-1:0]           m_col_index,
    output logic signed [gpf_pkg::SAMPLE_W-1:0] m_cell_value,
    output logic                                m_strict_peak,
    output logic                                m_flat_peak,
    output logic                                m_frame_end,
    output logic                                m_any_unbeaten
);
    import gpf_pkg::*;

    logic signed [SAMPLE_W-1:0] grid_mem [STORE_DEPTH];
    logic signed [SAMPLE_W-1:0] rdata_reg;
    logic signed [SAMPLE_W-1:0] center_reg;
    logic                       larger_reg, smaller_reg;
    logic                       unbeaten_reg;
    logic                       m_valid_reg;

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            grid_mem[cmd.wr_addr] <= s_sample;
        end
        if (cmd.rd_en) begin
            rdata_reg <= grid_mem[cmd.rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.cap_center) begin
            center_reg  <= rdata_reg;
            larger_reg  <= 1'b0;
            smaller_reg <= 1'b0;
        end else if (cmd.cmp_en && cmd.cmp_valid) begin
            larger_reg  <= larger_reg  || (rdata_reg > center_reg);
            smaller_reg <= smaller_reg || (rdata_reg < center_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unbeaten_reg <= 1'b0;
        end else if (cmd.scan_start) begin
            unbeaten_reg <= 1'b0;
        end else if (cmd.out_load) begin
            unbeaten_reg <= unbeaten_reg || !larger_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_row_index    <= cmd.out_row;
            m_col_index    <= cmd.out_col;
            m_cell_value   <= center_reg;
            m_strict_peak  <= !larger_reg && smaller_reg;
            m_flat_peak    <= !larger_reg && !smaller_reg;
            m_frame_end    <= cmd.frame_end;
            m_any_unbeaten <= cmd.frame_end && (unbeaten_reg || !larger_reg);
        end
    end

    assign m_valid        = m_valid_reg;
    assign stat.out_stall = m_valid_reg && !m_ready;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !(m_valid_reg && !m_ready))
        else $error("result overwritten before transaction completed");

    a_unbeaten_on_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_frame_end) |-> !m_any_unbeaten)
        else $error("any_unbeaten set away from frame end");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> (m_valid_reg && $stable(m_cell_value) &&
                                       $stable(m_row_index) && $stable(m_col_index)))
        else $error("waiting result changed before its transaction");

endmodule

// File: hw/rtl/grid_peak_finder_4_neighbour.sv
// channel  | handshake              | payload
// ---------+------------------------+-----------------------------------------------
// cfg      | cfg_valid / cfg_ready  | cfg_data (row_count)
// input    | s_valid / s_ready      | s_sample
// result   | m_valid / m_ready      | m_row_index m_col_index m_cell_value
//          |                        | m_strict_peak m_flat_peak m_frame_end m_any_unbeaten
//
// Loading stores one sample per cycle of s_valid; s_ready drops for the scan after the last sample.
// The scan handles each cell in steps set by the single read port of the grid store
// (center read, four neighbor reads, one compare, one output load).
// A stalled result output holds the scan at the output load; the last result may wait
// while loading of the next frame is already under way.
// Synchronous active-low reset returns to loading with row_count at 8; the store is not cleared.
module grid_peak_finder_4_neighbour #(
    parameter int COLS     = gpf_pkg::DEF_COLS,
    parameter int MAX_ROWS = gpf_pkg::DEF_MAX_ROWS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [gpf_pkg::ROWCNT_W-1:0]        cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [gpf_pkg::SAMPLE_W-1:0] s_sample,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [gpf_pkg::IDX_W-1:0]           m_row_index,
    output logic [gpf_pkg::IDX_W-1:0]           m_col_index,
    output logic signed [gpf_pkg::SAMPLE_W-1:0] m_cell_value,
    output logic                                m_strict_peak,
    output logic                                m_flat_peak,
    output logic                                m_frame_end,
    output logic                                m_any_unbeaten
);
    import gpf_pkg::*;

    gpf_cmd_t  cmd;
    gpf_stat_t stat;

    gpf_ctrl #(
        .COLS     (COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    gpf_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_sample       (s_sample),
        .cmd            (cmd),
        .stat           (stat),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_row_index    (m_row_index),
        .m_col_index    (m_col_index),
        .m_cell_value   (m_cell_value),
        .m_strict_peak  (m_strict_peak),
        .m_flat_peak    (m_flat_peak),
        .m_frame_end    (m_frame_end),
        .m_any_unbeaten (m_any_unbeaten)
    );

endmodule
